// ===== hdl/ptmu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmu_pkg
// Shared types and constants for the page table map/unmap engine.
// ----------------------------------------------------------------------------
package ptmu_pkg;

	localparam int TABLE_PAGES_DEF = 64;
	localparam int ENTRIES         = 512;
	localparam int IDX_W           = 9;
	localparam int VF_W            = 36;
	localparam int FRAME_W         = 40;
	localparam int LEAF_W          = 52;
	localparam int TU_W            = 7;
	localparam int ST_W            = 2;

	localparam logic OP_MAP   = 1'b0;
	localparam logic OP_UNMAP = 1'b1;

	localparam logic [ST_W-1:0] ST_OK         = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_MAPPED = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_DECIDE,
		S_ALLOC,
		S_LEAF,
		S_DONE
	} state_t;

	typedef struct packed {
		logic            clear;
		logic            load;
		logic            eval;
		logic            alloc;
		logic            wr_leaf;
		logic            finish;
		logic [ST_W-1:0] fin_status;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_ok;
		logic level_full;
		logic alloc_last;
		logic op_unmap;
		logic no_space;
		logic clear_last;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hdl/page_table_map_unmap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_map_unmap
// Four-level x86-64 page table map/unmap engine with internal table store.
// ----------------------------------------------------------------------------
// The walk from transaction accept to result valid is paced by the chain
//   of dependent level reads through the single table memory read port.
// Transactions are taken one at a time; a new one is accepted while the
//   previous result still waits at the output register.
// Reset: clears control state, then sweeps all TABLE_PAGES*512 entries (32768
//   at default) to zero the table memory; input is stalled during the sweep.
module page_table_map_unmap #(
	parameter int TABLE_PAGES = ptmu_pkg::TABLE_PAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ptmu_pkg::FRAME_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic [ptmu_pkg::VF_W-1:0]            virt_frame,
	input  logic [ptmu_pkg::FRAME_W-1:0]         phys_frame,
	input  logic                                 user_access,
	input  logic                                 cache_disable,
	input  logic                                 write_through,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ptmu_pkg::ST_W-1:0]            status,
	output logic [ptmu_pkg::LEAF_W-1:0]          leaf_entry,
	output logic [ptmu_pkg::TU_W-1:0]            tables_used,
	output logic                                 invalidate
);
	import ptmu_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	ptmu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptmu_dpath #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.virt_frame    (virt_frame),
		.phys_frame    (phys_frame),
		.user_access   (user_access),
		.cache_disable (cache_disable),
		.write_through (write_through),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.leaf_entry    (leaf_entry),
		.tables_used   (tables_used),
		.invalidate    (invalidate)
	);

endmodule

// ===== hdl/ptmu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmu_ctrl
// Sequencer for the table clear pass, the four-level walk, allocation and
// the leaf update.
// ----------------------------------------------------------------------------
module ptmu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ptmu_pkg::dp_sts_t sts,
	output ptmu_pkg::dp_cmd_t cmd
);
	import ptmu_pkg::*;

	state_t          state_q;
	state_t          state_d;
	logic [ST_W-1:0] result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= ST_OK;
		end else if (state_q == S_DECIDE) begin
			if (sts.op_unmap) begin
				result_q <= ST_NOT_MAPPED;
			end else begin
				result_q <= ST_NO_SPACE;
			end
		end else if (state_q == S_LEAF) begin
			result_q <= ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (sts.walk_ok && !sts.alloc_last) begin
					state_d = S_READ;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.op_unmap) begin
					state_d = sts.level_full ? S_LEAF : S_DONE;
				end else if (sts.no_space) begin
					state_d = S_DONE;
				end else begin
					state_d = sts.level_full ? S_LEAF : S_ALLOC;
				end
			end
			S_ALLOC: begin
				if (sts.alloc_last) state_d = S_LEAF;
			end
			S_LEAF: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.fin_status = result_q;
		in_stall       = 1'b1;
		unique case (state_q)
			S_CLEAR: cmd.clear = 1'b1;
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_EVAL:  cmd.eval    = sts.walk_ok;
			S_ALLOC: cmd.alloc   = 1'b1;
			S_LEAF:  cmd.wr_leaf = 1'b1;
			S_DONE:  cmd.finish  = sts.out_free;
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/ptmu_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmu_dpath
// Table memory, walk registers, page allocator and result register.
// ----------------------------------------------------------------------------
module ptmu_dpath #(
	parameter int TABLE_PAGES = ptmu_pkg::TABLE_PAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ptmu_pkg::dp_cmd_t                    cmd,
	output ptmu_pkg::dp_sts_t                    sts,
	input  logic                                 cfg_we,
	input  logic [ptmu_pkg::FRAME_W-1:0]         cfg_data,
	input  logic                                 opcode,
	input  logic [ptmu_pkg::VF_W-1:0]            virt_frame,
	input  logic [ptmu_pkg::FRAME_W-1:0]         phys_frame,
	input  logic                                 user_access,
	input  logic                                 cache_disable,
	input  logic                                 write_through,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ptmu_pkg::ST_W-1:0]            status,
	output logic [ptmu_pkg::LEAF_W-1:0]          leaf_entry,
	output logic [ptmu_pkg::TU_W-1:0]            tables_used,
	output logic                                 invalidate
);
	import ptmu_pkg::*;

	localparam int PW    = $clog2(TABLE_PAGES);
	localparam int AW    = PW + IDX_W;
	localparam int DEPTH = TABLE_PAGES * ENTRIES;
	localparam int CW    = $clog2(TABLE_PAGES + 1);
	localparam int EW    = FRAME_W + 1;

	// entry = {stale, frame, present}; stale marks a write into a page that
	// was not yet allocated, such an entry reads as empty once it is
	logic [EW:0]        mem [DEPTH];
	logic [EW:0]        rd_data_q;
	logic [AW-1:0]      clr_addr_q;
	logic [FRAME_W-1:0] base_q;
	logic [1:0]         level_q;
	logic [PW-1:0]      page_q;
	logic [CW-1:0]      nfp_q;
	logic               out_valid_q;

	logic               op_q;
	logic [VF_W-1:0]    vf_q;
	logic [FRAME_W-1:0] pf_q;
	logic               us_q;
	logic               pcd_q;
	logic               pwt_q;

	logic [ST_W-1:0]    status_q;
	logic [LEAF_W-1:0]  leaf_q;
	logic [TU_W-1:0]    tables_q;
	logic               inval_q;

	logic [IDX_W-1:0]   idx;
	logic [AW-1:0]      acc_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [EW-1:0]      wr_data;
	logic               wr_stale;
	logic               rd_stale;
	logic [FRAME_W-1:0] link_frame;
	logic [FRAME_W-1:0] off;
	logic [1:0]         missing;
	logic [CW:0]        need;

	always_comb begin
		unique case (level_q)
			2'd0:    idx = vf_q[4*IDX_W-1:3*IDX_W];
			2'd1:    idx = vf_q[3*IDX_W-1:2*IDX_W];
			2'd2:    idx = vf_q[2*IDX_W-1:IDX_W];
			default: idx = vf_q[IDX_W-1:0];
		endcase
	end

	assign acc_addr   = {page_q, idx};
	assign link_frame = base_q + FRAME_W'(nfp_q);
	assign off        = rd_data_q[EW-1:1] - base_q;
	assign missing    = 2'd3 - level_q;
	assign need       = (CW+1)'(nfp_q) + (CW+1)'(missing);
	assign wr_stale   = !cmd.clear && (CW'(page_q) >= (nfp_q + CW'(cmd.alloc)));
	assign rd_stale   = rd_data_q[EW] && (CW'(page_q) < nfp_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = acc_addr;
		wr_data = '0;
		if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
		end else if (cmd.alloc) begin
			wr_en   = 1'b1;
			wr_data = {link_frame, 1'b1};
		end else if (cmd.wr_leaf) begin
			wr_en   = 1'b1;
			wr_data = (op_q == OP_MAP) ? {pf_q, 1'b1} : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_stale, wr_data};
		end
		rd_data_q <= mem[acc_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			base_q      <= '0;
			level_q     <= '0;
			page_q      <= '0;
			nfp_q       <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_addr_q <= clr_addr_q + AW'(1);
			if (cfg_we) base_q <= cfg_data;
			if (cmd.load) begin
				level_q <= '0;
				page_q  <= '0;
			end else if (cmd.eval) begin
				level_q <= level_q + 2'd1;
				page_q  <= off[PW-1:0];
			end else if (cmd.alloc) begin
				level_q <= level_q + 2'd1;
				page_q  <= nfp_q[PW-1:0];
				nfp_q   <= nfp_q + CW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			vf_q  <= virt_frame;
			pf_q  <= phys_frame;
			us_q  <= user_access;
			pcd_q <= cache_disable;
			pwt_q <= write_through;
		end
		if (cmd.finish) begin
			status_q <= cmd.fin_status;
			inval_q  <= (cmd.fin_status == ST_OK);
			tables_q <= TU_W'(nfp_q);
			if (cmd.fin_status == ST_OK && op_q == OP_MAP) begin
				leaf_q <= {pf_q, 7'b0, pcd_q, pwt_q, us_q, 2'b11};
			end else begin
				leaf_q <= '0;
			end
		end
	end

	always_comb begin
		sts.walk_ok    = rd_data_q[0] && !rd_stale && (off < FRAME_W'(TABLE_PAGES));
		sts.level_full = (level_q == 2'd3);
		sts.alloc_last = (level_q == 2'd2);
		sts.op_unmap   = (op_q == OP_UNMAP);
		sts.no_space   = (need > (CW+1)'(TABLE_PAGES));
		sts.clear_last = (clr_addr_q == AW'(DEPTH - 1));
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign leaf_entry  = leaf_q;
	assign tables_used = tables_q;
	assign invalidate  = inval_q;

endmodule

// ===== hdl/ptmu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmu_checker
// Port-level checks on the result channel of the page table engine.
// ----------------------------------------------------------------------------
module ptmu_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [ptmu_pkg::ST_W-1:0]    status,
	input logic [ptmu_pkg::LEAF_W-1:0]  leaf_entry,
	input logic                         invalidate
);
	import ptmu_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(leaf_entry))
		else $error("result changed while stalled");

	a_ok_inval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_OK) == invalidate))
		else $error("invalidate does not match status");

	a_fail_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> leaf_entry == '0)
		else $error("leaf reported on failed transaction");

	a_leaf_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && leaf_entry != '0 |-> leaf_entry[1:0] == 2'b11 && leaf_entry[11:5] == '0)
		else $error("malformed leaf entry");

endmodule

bind page_table_map_unmap ptmu_checker u_ptmu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.leaf_entry (leaf_entry),
	.invalidate (invalidate)
);
